### hw/rtl/bsp_pkg.sv
package bsp_pkg;

    // fixed field widths
    localparam int POINT_W  = 63;
    localparam int RADIUS_W = 20;
    localparam int RSUM_W   = RADIUS_W + 1;

    // collider kinds
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // response codes
    localparam logic [1:0] RESP_NONE          = 2'd0;
    localparam logic [1:0] RESP_SPHERE_SPHERE = 2'd1;
    localparam logic [1:0] RESP_SPHERE_FIRST  = 2'd2;
    localparam logic [1:0] RESP_SPHERE_SECOND = 2'd3;

    // which test a pair gets
    typedef enum logic [2:0] {
        PAIR_SKIP,
        PAIR_BOX_BOX,
        PAIR_SPHERE_BOX,
        PAIR_BOX_SPHERE,
        PAIR_SPHERE_SPHERE
    } pair_mode_t;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } bsp_adv_t;

    // axis datapath steering
    typedef struct packed {
        logic center_first;
        logic clamp;
    } bsp_axis_ctl_t;

endpackage

### hw/rtl/bsp_axis.sv
module bsp_axis #(
    parameter int COORD_BITS = 21
) (
    input  logic                      clk,
    input  bsp_pkg::bsp_adv_t         adv,
    input  bsp_pkg::bsp_axis_ctl_t    ctl,
    input  logic [COORD_BITS-1:0]     first_a,
    input  logic [COORD_BITS-1:0]     first_b,
    input  logic [COORD_BITS-1:0]     second_a,
    input  logic [COORD_BITS-1:0]     second_b,
    output logic                      overlap,
    output logic [2*COORD_BITS-1:0]   sq
);
    import bsp_pkg::*;

    localparam int C = COORD_BITS;

    logic signed [C-1:0] a1;
    logic signed [C-1:0] b1;
    logic signed [C-1:0] a2;
    logic signed [C-1:0] b2;
    logic signed [C-1:0] ctr;
    logic signed [C-1:0] lo;
    logic signed [C-1:0] hi;
    logic signed [C-1:0] p_hi;
    logic signed [C-1:0] p_clamp;
    logic signed [C-1:0] t_next;
    logic                ov_next;

    logic signed [C-1:0] c_reg;
    logic signed [C-1:0] t_reg;
    logic                ov1_reg;
    logic signed [C:0]   diff;
    logic        [C:0]   mag;
    logic        [C-1:0] d_next;
    logic        [C-1:0] d_reg;
    logic                ov2_reg;
    logic [2*C-1:0]      sq_next;
    logic [2*C-1:0]      sq_reg;
    logic                ov3_reg;

    assign a1 = first_a;
    assign b1 = first_b;
    assign a2 = second_a;
    assign b2 = second_b;

    // stage 1: box-box compare, clamp of center into box
    always_comb
    begin
        ov_next = (a1 <= b2) && (b1 >= a2);
        ctr     = ctl.center_first ? a1 : a2;
        lo      = ctl.center_first ? a2 : a1;
        hi      = ctl.center_first ? b2 : b1;
        p_hi    = (ctr < hi) ? ctr : hi;
        p_clamp = (p_hi < lo) ? lo : p_hi;
        t_next  = ctl.clamp ? p_clamp : a2;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            c_reg   <= ctr;
            t_reg   <= t_next;
            ov1_reg <= ov_next;
        end
    end

    // stage 2: absolute difference
    always_comb
    begin
        diff   = {t_reg[C-1], t_reg} - {c_reg[C-1], c_reg};
        mag    = diff[C] ? (~diff + 1'b1) : diff;
        d_next = mag[C-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            d_reg   <= d_next;
            ov2_reg <= ov1_reg;
        end
    end

    // stage 3: square
    assign sq_next = {{C{1'b0}}, d_reg} * {{C{1'b0}}, d_reg};

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            sq_reg  <= sq_next;
            ov3_reg <= ov2_reg;
        end
    end

    assign overlap = ov3_reg;
    assign sq      = sq_reg;

endmodule

### hw/rtl/box_sphere_pair_collision_test_unit.sv
// box/sphere pair collision test
//
// input channel: one word per object pair (kind, dynamic flag, two packed
// corner/center points and a radius per object), moved when in_valid is
// high and in_stall is low. output channel: one word per pair (hit and
// response_code), moved when out_valid is high and out_stall is low.
//
// four register stages: clamp and box compares, absolute differences,
// squares of the differences and of the radius term, then the sum and
// final compare into the output register, from which a pair leaves. one
// pair per cycle is accepted while the output is taken.
//
// reset clears every stage valid bit, so the pipeline comes up empty and
// in_stall low. when the receiver stalls, the output word holds and the
// stages behind it keep filling empty slots; in_stall rises only once all
// four stages hold a pair.
module box_sphere_pair_collision_test_unit #(
    parameter int COORD_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          first_kind,
    input  logic                          first_dynamic,
    input  logic [bsp_pkg::POINT_W-1:0]   first_point_a,
    input  logic [bsp_pkg::POINT_W-1:0]   first_point_b,
    input  logic [bsp_pkg::RADIUS_W-1:0]  first_radius,
    input  logic                          second_kind,
    input  logic                          second_dynamic,
    input  logic [bsp_pkg::POINT_W-1:0]   second_point_a,
    input  logic [bsp_pkg::POINT_W-1:0]   second_point_b,
    input  logic [bsp_pkg::RADIUS_W-1:0]  second_radius,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [1:0]                    response_code
);
    import bsp_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int RSQ_W = 2 * RSUM_W;
    // three squares summed need two more bits
    localparam int SUM_W = (SQ_W + 2 > RSQ_W) ? SQ_W + 2 : RSQ_W;

    // stage valid bits
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;

    bsp_adv_t adv;
    logic     adv4;

    // stage 0 decode
    pair_mode_t    mode_next;
    logic [1:0]    pend_next;
    logic [RSUM_W-1:0] r_next;
    bsp_axis_ctl_t axis_ctl;

    // sideband through the stages
    pair_mode_t        mode1_reg;
    pair_mode_t        mode2_reg;
    pair_mode_t        mode3_reg;
    pair_mode_t        mode4_reg;
    logic [1:0]        pend1_reg;
    logic [1:0]        pend2_reg;
    logic [1:0]        pend3_reg;
    logic [RSUM_W-1:0] r1_reg;
    logic [RSUM_W-1:0] r2_reg;
    logic [RSQ_W-1:0]  rsq_next;
    logic [RSQ_W-1:0]  rsq3_reg;

    // per-axis results, aligned with stage 3
    logic            ov [3];
    logic [SQ_W-1:0] sq [3];

    // stage 4
    logic [SUM_W-1:0] dist2;
    logic [SUM_W-1:0] rsq_ext;
    logic             hit_next;
    logic [1:0]       code_next;
    logic             hit_reg;
    logic [1:0]       code_reg;

    // a stage loads when it is empty or its word moves on
    assign adv4   = !v4_reg || !out_stall;
    assign adv.s3 = !v3_reg || adv4;
    assign adv.s2 = !v2_reg || adv.s3;
    assign adv.s1 = !v1_reg || adv.s2;
    assign in_stall = !adv.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv.s1)
                v1_reg <= in_valid;
            if (adv.s2)
                v2_reg <= v1_reg;
            if (adv.s3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // pair classification and pending response
    always_comb
    begin
        mode_next = PAIR_SKIP;
        pend_next = RESP_NONE;
        r_next    = '0;
        if (first_dynamic || second_dynamic)
        begin
            unique case ({first_kind, second_kind})
                {KIND_BOX, KIND_BOX}:
                begin
                    mode_next = PAIR_BOX_BOX;
                end
                {KIND_SPHERE, KIND_BOX}:
                begin
                    mode_next = PAIR_SPHERE_BOX;
                    pend_next = (first_dynamic && second_dynamic) ? RESP_NONE
                                                                  : RESP_SPHERE_FIRST;
                    r_next    = {1'b0, first_radius};
                end
                {KIND_BOX, KIND_SPHERE}:
                begin
                    mode_next = PAIR_BOX_SPHERE;
                    pend_next = (first_dynamic && second_dynamic) ? RESP_NONE
                                                                  : RESP_SPHERE_SECOND;
                    r_next    = {1'b0, second_radius};
                end
                default:
                begin
                    mode_next = PAIR_SPHERE_SPHERE;
                    pend_next = RESP_SPHERE_SPHERE;
                    r_next    = {1'b0, first_radius} + {1'b0, second_radius};
                end
            endcase
        end
    end

    // center is the first object for sphere-box and sphere-sphere
    assign axis_ctl.center_first = (mode_next != PAIR_BOX_SPHERE);
    assign axis_ctl.clamp        = (mode_next == PAIR_SPHERE_BOX)
                                || (mode_next == PAIR_BOX_SPHERE);

    genvar ax;
    generate
        for (ax = 0; ax < 3; ax++)
        begin : g_axis
            bsp_axis #(
                .COORD_BITS (COORD_BITS)
            ) u_axis (
                .clk      (clk),
                .adv      (adv),
                .ctl      (axis_ctl),
                .first_a  (first_point_a[ax*C +: C]),
                .first_b  (first_point_b[ax*C +: C]),
                .second_a (second_point_a[ax*C +: C]),
                .second_b (second_point_b[ax*C +: C]),
                .overlap  (ov[ax]),
                .sq       (sq[ax])
            );
        end
    endgenerate

    // radius term and mode follow the axis datapath
    assign rsq_next = {{RSUM_W{1'b0}}, r2_reg} * {{RSUM_W{1'b0}}, r2_reg};

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            mode1_reg <= mode_next;
            pend1_reg <= pend_next;
            r1_reg    <= r_next;
        end
        if (adv.s2)
        begin
            mode2_reg <= mode1_reg;
            pend2_reg <= pend1_reg;
            r2_reg    <= r1_reg;
        end
        if (adv.s3)
        begin
            mode3_reg <= mode2_reg;
            pend3_reg <= pend2_reg;
            rsq3_reg  <= rsq_next;
        end
    end

    // sum of squares and final compare
    always_comb
    begin
        dist2   = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
        rsq_ext = SUM_W'(rsq3_reg);
        unique case (mode3_reg)
            PAIR_BOX_BOX:       hit_next = ov[0] && ov[1] && ov[2];
            PAIR_SPHERE_BOX:    hit_next = dist2 < rsq_ext;
            PAIR_BOX_SPHERE:    hit_next = dist2 < rsq_ext;
            PAIR_SPHERE_SPHERE: hit_next = dist2 <= rsq_ext;
            default:            hit_next = 1'b0;
        endcase
        code_next = hit_next ? pend3_reg : RESP_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            hit_reg   <= hit_next;
            code_reg  <= code_next;
            mode4_reg <= mode3_reg;
        end
    end

    assign out_valid     = v4_reg;
    assign hit           = hit_reg;
    assign response_code = code_reg;

    // a response is only reported with a hit
    a_code_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && response_code != RESP_NONE) |-> hit)
        else $error("response code without hit");

    // input back-pressure only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with a free stage");

    // output drains when nothing follows in stage 3
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !v3_reg) |=> !out_valid)
        else $error("output word repeated");

    // sphere-sphere response only from a sphere-sphere pair
    a_ss_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode4_reg != PAIR_SPHERE_SPHERE)
            |-> (response_code != RESP_SPHERE_SPHERE))
        else $error("sphere-sphere code on another pair");

endmodule
